>>> design/rhpq_pkg.sv
// rhpq_pkg: shared constants and types of the radix heap priority queue
// no dependencies; used by every other file of the block but rhpq_ram

package rhpq_pkg;

    localparam int CAPACITY_DEF     = 1024;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 20;

    // age stamp width, far beyond any reachable push count
    localparam int STAMP_BITS = 48;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic last_rd;
        logic move;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pop_ok;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

>>> design/rhpq_if.sv
// rhpq_in_if / rhpq_out_if: valid-ready channels of the priority queue
// depends on rhpq_pkg for default widths

interface rhpq_in_if #(
    parameter int KEY_BITS     = rhpq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = rhpq_pkg::PAYLOAD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, output opcode, output key, output payload, input ready);
    modport sink   (input valid, input opcode, input key, input payload, output ready);
endinterface

interface rhpq_out_if #(
    parameter int KEY_BITS     = rhpq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = rhpq_pkg::PAYLOAD_BITS_DEF,
    parameter int OCC_BITS     = $clog2(rhpq_pkg::CAPACITY_DEF + 1)
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     popped_key;
    logic [PAYLOAD_BITS-1:0] popped_payload;
    logic                    now_empty;
    logic [OCC_BITS-1:0]     occupancy;

    modport source (output valid, output status, output popped_key, output popped_payload,
                    output now_empty, output occupancy, input ready);
    modport sink   (input valid, input status, input popped_key, input popped_payload,
                    input now_empty, input occupancy, output ready);
endinterface

>>> design/rhpq_ram.sv
// rhpq_ram: generic single write, single read ram with registered read
// no dependencies

module rhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

>>> design/rhpq_ctrl.sv
// rhpq_ctrl: sequencer of the priority queue (accept, scan, move, deliver)
// depends on rhpq_pkg

module rhpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_opcode,
    input  rhpq_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output rhpq_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_opcode == rhpq_pkg::OP_POP && i_sts.pop_ok) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // fetch the tail entry while the last compare settles
                o_cmd.last_rd = 1'b1;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> design/rhpq_dp.sv
// rhpq_dp: entry store, minimum search and result register of the queue
// depends on rhpq_pkg and rhpq_ram

module rhpq_dp #(
    parameter int CAPACITY     = rhpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS     = rhpq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = rhpq_pkg::PAYLOAD_BITS_DEF,
    parameter int OCC_BITS     = $clog2(CAPACITY + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rhpq_pkg::t_cmd          i_cmd,
    input  logic                    i_opcode,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic                    i_out_ready,
    output rhpq_pkg::t_sts          o_sts,
    output logic                    o_out_valid,
    output logic [1:0]              o_status,
    output logic [KEY_BITS-1:0]     o_popped_key,
    output logic [PAYLOAD_BITS-1:0] o_popped_payload,
    output logic                    o_now_empty,
    output logic [OCC_BITS-1:0]     o_occupancy
);
    localparam int AW = $clog2(CAPACITY);
    localparam int SB = rhpq_pkg::STAMP_BITS;
    localparam int EW = KEY_BITS + PAYLOAD_BITS + SB;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_KEY_BELOW = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    logic [OCC_BITS-1:0]     r_count;
    logic [KEY_BITS-1:0]     r_last;
    logic [SB-1:0]           r_stamp;
    logic [AW-1:0]           r_idx;
    logic                    r_cmp_vld;
    logic                    r_cmp_first;
    logic [AW-1:0]           r_cmp_idx;
    logic [KEY_BITS-1:0]     r_best_key;
    logic [PAYLOAD_BITS-1:0] r_best_pay;
    logic [SB-1:0]           r_best_stamp;
    logic [AW-1:0]           r_best_idx;
    logic [1:0]              r_res_status;
    logic [KEY_BITS-1:0]     r_res_key;
    logic [PAYLOAD_BITS-1:0] r_res_pay;
    logic                    r_out_valid;
    logic [1:0]              r_out_status;
    logic [KEY_BITS-1:0]     r_out_key;
    logic [PAYLOAD_BITS-1:0] r_out_pay;
    logic                    r_out_empty;
    logic [OCC_BITS-1:0]     r_out_occ;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [EW-1:0]           wr_data;
    logic [AW-1:0]           rd_addr;
    logic [EW-1:0]           rd_data;
    logic [OCC_BITS-1:0]     count_m1;
    logic                    key_below;
    logic                    full;
    logic                    push_ok;
    logic [KEY_BITS-1:0]     c_key;
    logic [PAYLOAD_BITS-1:0] c_pay;
    logic [SB-1:0]           c_stamp;
    logic                    better;

    assign count_m1  = r_count - OCC_BITS'(1);
    assign key_below = i_key < r_last;
    assign full      = r_count == OCC_BITS'(CAPACITY);
    assign push_ok   = !key_below && !full;

    assign c_key   = rd_data[EW-1 -: KEY_BITS];
    assign c_pay   = rd_data[SB +: PAYLOAD_BITS];
    assign c_stamp = rd_data[SB-1:0];
    // smallest key wins, newest entry among equal keys
    assign better  = r_cmp_first || (c_key < r_best_key) ||
                     (c_key == r_best_key && c_stamp > r_best_stamp);

    assign rd_addr = i_cmd.last_rd ? count_m1[AW-1:0] : r_idx;
    assign wr_en   = (i_cmd.accept && i_opcode == rhpq_pkg::OP_PUSH && push_ok) || i_cmd.move;
    assign wr_addr = i_cmd.move ? r_best_idx : r_count[AW-1:0];
    // move the tail entry into the freed slot to keep the store packed
    assign wr_data = i_cmd.move ? rd_data : {i_key, i_payload, r_stamp};

    rhpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_sts.pop_ok   = r_count != '0;
    assign o_sts.scan_end = OCC_BITS'(r_idx) == count_m1;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last      <= '0;
            r_stamp     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.accept) begin
                r_res_key <= '0;
                r_res_pay <= '0;
                if (i_opcode == rhpq_pkg::OP_PUSH) begin
                    if (key_below) begin
                        r_res_status <= ST_KEY_BELOW;
                    end else if (full) begin
                        r_res_status <= ST_FULL;
                    end else begin
                        r_res_status <= ST_OK;
                        r_count      <= r_count + OCC_BITS'(1);
                        r_stamp      <= r_stamp + SB'(1);
                    end
                end else begin
                    r_res_status <= (r_count == '0) ? ST_EMPTY : ST_OK;
                end
            end
            if (i_cmd.move) begin
                r_count   <= count_m1;
                r_last    <= r_best_key;
                r_res_key <= r_best_key;
                r_res_pay <= r_best_pay;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + AW'(1);
        end
        r_cmp_idx   <= r_idx;
        r_cmp_first <= r_idx == '0;
        if (r_cmp_vld && better) begin
            r_best_key   <= c_key;
            r_best_pay   <= c_pay;
            r_best_stamp <= c_stamp;
            r_best_idx   <= r_cmp_idx;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_key    <= r_res_key;
            r_out_pay    <= r_res_pay;
            r_out_empty  <= r_count == '0;
            r_out_occ    <= r_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_popped_key     = r_out_key;
    assign o_popped_payload = r_out_pay;
    assign o_now_empty      = r_out_empty;
    assign o_occupancy      = r_out_occ;
endmodule

>>> design/radix_heap_priority_queue.sv
// radix_heap_priority_queue: monotone min priority queue, newest entry wins ties
// push or error: taken in idle, result loaded into the output register from the done state;
// a pop of n entries scans them all, one compare per cycle over the single read port of the store
// flow: one word at a time, ready only in idle; a new word is taken while a result waits
// reset: synchronous active low; queue empty, last minimum zero, no clearing pass
// depends on rhpq_pkg, rhpq_if, rhpq_ram, rhpq_ctrl, rhpq_dp

module radix_heap_priority_queue #(
    parameter int CAPACITY     = rhpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS     = rhpq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = rhpq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rhpq_in_if.sink      i_in,
    rhpq_out_if.source   o_out
);
    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    rhpq_pkg::t_cmd cmd;
    rhpq_pkg::t_sts sts;

    rhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    rhpq_dp #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .OCC_BITS     (OCC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_in.opcode),
        .i_key            (i_in.key),
        .i_payload        (i_in.payload),
        .i_out_ready      (o_out.ready),
        .o_sts            (sts),
        .o_out_valid      (o_out.valid),
        .o_status         (o_out.status),
        .o_popped_key     (o_out.popped_key),
        .o_popped_payload (o_out.popped_payload),
        .o_now_empty      (o_out.now_empty),
        .o_occupancy      (o_out.occupancy)
    );
endmodule
